[src/opd_pkg.sv]
package opd_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int OUT_CNT_W  = 7;
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int GROUP      = 8;
    localparam int NGROUP     = (DEPTH + GROUP - 1) / GROUP;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_RED,
        ST_DEC
    } state_t;

    typedef struct packed {
        logic shift;
        logic compare;
        logic occupied;
    } cell_ctl_t;

endpackage

[src/opd_cell.sv]
module opd_cell (
    input  logic                               aclk,
    input  opd_pkg::cell_ctl_t                 ctl,
    input  logic [opd_pkg::DATA_WIDTH-1:0]     key,
    input  logic [opd_pkg::DATA_WIDTH-1:0]     data_in,
    output logic [opd_pkg::DATA_WIDTH-1:0]     data_out,
    output logic                               hit
);

    logic [opd_pkg::DATA_WIDTH-1:0] data_reg;
    logic [opd_pkg::DATA_WIDTH-1:0] data_next;
    logic                           hit_reg;
    logic                           hit_next;

    always_comb begin
        data_next = ctl.shift ? data_in : data_reg;
        hit_next  = ctl.compare ? (ctl.occupied && (data_reg == key)) : hit_reg;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
    end

    assign data_out = data_reg;
    assign hit      = hit_reg;

endmodule

[src/opd_hit_reduce.sv]
module opd_hit_reduce (
    input  logic                       aclk,
    input  logic                       load,
    input  logic [opd_pkg::DEPTH-1:0]  hits,
    output logic                       any_hit
);

    localparam int PAD_W = opd_pkg::NGROUP * opd_pkg::GROUP;

    logic [PAD_W-1:0]            hits_pad;
    logic [opd_pkg::NGROUP-1:0]  part_reg;
    logic [opd_pkg::NGROUP-1:0]  part_next;

    assign hits_pad = PAD_W'(hits);

    always_comb begin
        for (int g = 0; g < opd_pkg::NGROUP; g++) begin
            part_next[g] = load ? |hits_pad[g*opd_pkg::GROUP +: opd_pkg::GROUP] : part_reg[g];
        end
    end

    always_ff @(posedge aclk) begin
        part_reg <= part_next;
    end

    assign any_hit = |part_reg;

endmodule

[src/order_preserving_dedup_core.sv]
// An input is registered, then compared, OR-reduced and decided; the result is registered.
// The core takes one item at a time; the input waits while an item is in the
// compare / OR-reduce / decide sequence over the cell row.
// A result held on the output does not block the next input transfer.
// Reset (aresetn low, synchronous): state, count and output valid clear; cell contents
// are not reset and only occupied cells take part in the compare.
module order_preserving_dedup_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic signed [opd_pkg::VALUE_W-1:0]     s_value,
    input  logic                                   s_last,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    output logic signed [opd_pkg::VALUE_W-1:0]     m_item_value,
    output logic                                   m_kept,
    output logic [opd_pkg::OUT_CNT_W-1:0]          m_distinct_count,
    output logic                                   m_overflow,
    output logic                                   m_set_end,
    output logic                                   m_valid,
    input  logic                                   m_ready
);

    localparam int DW = opd_pkg::DATA_WIDTH;
    localparam int CW = opd_pkg::COUNT_W;

    opd_pkg::state_t state_reg, state_next;

    logic [opd_pkg::VALUE_W-1:0] value_reg, value_next;
    logic                        last_reg, last_next;
    logic [CW-1:0]               count_reg, count_next;

    logic [opd_pkg::VALUE_W-1:0] out_value_reg, out_value_next;
    logic                        out_kept_reg, out_kept_next;
    logic [opd_pkg::OUT_CNT_W-1:0] out_count_reg, out_count_next;
    logic                        out_ovf_reg, out_ovf_next;
    logic                        out_end_reg, out_end_next;
    logic                        m_valid_reg, m_valid_next;

    logic          in_xfer;
    logic          dec_fire;
    logic          compare;
    logic          reduce_load;
    logic          any_hit;
    logic          kept;
    logic          ovf;
    logic [CW-1:0] count_upd;
    logic [DW-1:0] key;

    logic [opd_pkg::DEPTH-1:0] hits;
    logic [DW-1:0]             chain [opd_pkg::DEPTH];

    assign key     = DW'($unsigned(value_reg));
    assign in_xfer = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            opd_pkg::ST_IDLE: if (s_valid) state_next = opd_pkg::ST_CMP;
            opd_pkg::ST_CMP:  state_next = opd_pkg::ST_RED;
            opd_pkg::ST_RED:  state_next = opd_pkg::ST_DEC;
            opd_pkg::ST_DEC:  if (!m_valid_reg || m_ready) state_next = opd_pkg::ST_IDLE;
            default:          state_next = opd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        compare     = 1'b0;
        reduce_load = 1'b0;
        dec_fire    = 1'b0;
        unique case (state_reg)
            opd_pkg::ST_IDLE: s_ready     = 1'b1;
            opd_pkg::ST_CMP:  compare     = 1'b1;
            opd_pkg::ST_RED:  reduce_load = 1'b1;
            opd_pkg::ST_DEC:  dec_fire    = !m_valid_reg || m_ready;
            default:          s_ready     = 1'b0;
        endcase
    end

    always_comb begin
        kept      = !any_hit && (count_reg < CW'(opd_pkg::DEPTH));
        ovf       = !any_hit && !(count_reg < CW'(opd_pkg::DEPTH));
        count_upd = count_reg + CW'(kept);

        value_next = in_xfer ? $unsigned(s_value) : value_reg;
        last_next  = in_xfer ? s_last : last_reg;
        count_next = count_reg;
        if (dec_fire) begin
            count_next = last_reg ? '0 : count_upd;
        end

        out_value_next = out_value_reg;
        out_kept_next  = out_kept_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        out_end_next   = out_end_reg;
        if (dec_fire) begin
            out_value_next = value_reg;
            out_kept_next  = kept;
            out_count_next = opd_pkg::OUT_CNT_W'(count_upd);
            out_ovf_next   = ovf;
            out_end_next   = last_reg;
        end

        m_valid_next = dec_fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= opd_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg     <= value_next;
        last_reg      <= last_next;
        out_value_reg <= out_value_next;
        out_kept_reg  <= out_kept_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
        out_end_reg   <= out_end_next;
    end

    // New distinct values enter at cell 0 and push older ones down the row,
    // so cells below count_reg are the occupied ones.
    for (genvar i = 0; i < opd_pkg::DEPTH; i++) begin : g_cell
        opd_pkg::cell_ctl_t ctl;
        logic [DW-1:0]      din;

        assign ctl.shift    = dec_fire && kept;
        assign ctl.compare  = compare;
        assign ctl.occupied = CW'(i) < count_reg;

        if (i == 0) begin : g_head
            assign din = key;
        end else begin : g_body
            assign din = chain[i-1];
        end

        opd_cell u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .key      (key),
            .data_in  (din),
            .data_out (chain[i]),
            .hit      (hits[i])
        );
    end

    opd_hit_reduce u_reduce (
        .aclk    (aclk),
        .load    (reduce_load),
        .hits    (hits),
        .any_hit (any_hit)
    );

    assign m_item_value     = $signed(out_value_reg);
    assign m_kept           = out_kept_reg;
    assign m_distinct_count = out_count_reg;
    assign m_overflow       = out_ovf_reg;
    assign m_set_end        = out_end_reg;
    assign m_valid          = m_valid_reg;

endmodule

[src/opd_checker.sv]
module opd_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic signed [opd_pkg::VALUE_W-1:0]     m_item_value,
    input logic                                   m_kept,
    input logic [opd_pkg::OUT_CNT_W-1:0]          m_distinct_count,
    input logic                                   m_overflow,
    input logic                                   m_valid,
    input logic                                   m_ready
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item_value))
        else $error("result dropped or changed while stalled");

    a_kept_not_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kept |-> !m_overflow && (m_distinct_count != '0))
        else $error("kept result with overflow or zero count");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_distinct_count == opd_pkg::OUT_CNT_W'(opd_pkg::DEPTH))
        else $error("overflow flagged with store not full");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind order_preserving_dedup_core opd_checker u_opd_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic signed [opd_pkg::VALUE_W-1:0] value;
        logic                               last;
    } element_t;

    typedef struct packed {
        logic signed [opd_pkg::VALUE_W-1:0] item_value;
        logic                               kept;
        logic [opd_pkg::OUT_CNT_W-1:0]      distinct_count;
        logic                               overflow;
        logic                               set_end;
    } verdict_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic signed [opd_pkg::VALUE_W-1:0] s_value = '0;
    logic                               s_last = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic signed [opd_pkg::VALUE_W-1:0] m_item_value;
    logic                               m_kept;
    logic [opd_pkg::OUT_CNT_W-1:0]      m_distinct_count;
    logic                               m_overflow;
    logic                               m_set_end;
    logic                               m_valid;
    logic                               m_ready = 1'b0;

    element_t pending_items[$];
    verdict_t due_results[$];

    logic [opd_pkg::DATA_WIDTH-1:0] kept_values[opd_pkg::DEPTH];
    int kept_total = 0;

    int sender_idle_pct = 19;
    int receiver_stall_pct = 70;
    int mismatch_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int overflow_seen = 0;
    int sets_closed = 0;
    int items_queued = 0;

    order_preserving_dedup_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_value          (s_value),
        .s_last           (s_last),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .m_item_value     (m_item_value),
        .m_kept           (m_kept),
        .m_distinct_count (m_distinct_count),
        .m_overflow       (m_overflow),
        .m_set_end        (m_set_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // a new value is stored if there is room; store empties after the marked element
    function automatic verdict_t predict_dedup(element_t e);
        logic [opd_pkg::DATA_WIDTH-1:0] key;
        bit                             hit;
        verdict_t                       r;
        key = e.value[opd_pkg::DATA_WIDTH-1:0];
        hit = 1'b0;
        for (int i = 0; i < kept_total; i++) begin
            if (kept_values[i] == key)
                hit = 1'b1;
        end
        r.item_value = e.value;
        r.kept = 1'b0;
        r.overflow = 1'b0;
        r.set_end = e.last;
        if (!hit) begin
            if (kept_total < opd_pkg::DEPTH) begin
                kept_values[kept_total] = key;
                kept_total++;
                r.kept = 1'b1;
            end else begin
                r.overflow = 1'b1;
            end
        end
        r.distinct_count = opd_pkg::OUT_CNT_W'(kept_total);
        if (e.last)
            kept_total = 0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] MISMATCH %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    task automatic push_element(input logic signed [opd_pkg::VALUE_W-1:0] v, input logic l);
        element_t e;
        e.value = v;
        e.last = l;
        pending_items.push_back(e);
        items_queued++;
    endtask

    // values drawn from a small pool, so most elements repeat
    task automatic push_pool_set();
        logic [31:0] pool[6];
        int          psize;
        int          len;
        psize = $urandom_range(6, 1);
        len = $urandom_range(14, 1);
        for (int i = 0; i < psize; i++) begin
            case ($urandom_range(5))
                0: pool[i] = 32'h8000_0000;
                1: pool[i] = 32'h7fff_ffff;
                2: pool[i] = 32'h0;
                3: pool[i] = 32'hffff_ffff;
                default: pool[i] = $urandom;
            endcase
        end
        for (int i = 0; i < len; i++)
            push_element(pool[$urandom_range(psize - 1)], i == len - 1);
    endtask

    task automatic push_random_set();
        int len;
        len = $urandom_range(10, 1);
        for (int i = 0; i < len; i++)
            push_element($urandom, i == len - 1);
    endtask

    // fills the store, then new values overflow and repeats of stored ones do not
    task automatic push_full_set();
        logic [31:0] base;
        base = $urandom;
        for (int i = 0; i < opd_pkg::DEPTH; i++) begin
            push_element(base + i, 1'b0);
            if ($urandom_range(9) == 0)
                push_element(base + $urandom_range(i), 1'b0);
        end
        push_element(base + opd_pkg::DEPTH, 1'b0);
        push_element(base + 32'd1000, 1'b0);
        push_element(base + 3, 1'b0);
        push_element(base + opd_pkg::DEPTH - 1, 1'b0);
        push_element(base + 32'd2000, 1'b1);
    endtask

    task automatic build_phase(input int target, input bit with_full);
        int start;
        int pick;
        start = items_queued;
        if (with_full)
            push_full_set();
        while (items_queued - start < target) begin
            pick = $urandom_range(99);
            if (pick < 4)
                push_full_set();
            else if (pick < 50)
                push_pool_set();
            else if (pick < 85)
                push_random_set();
            else
                push_element($urandom, 1'b1);
        end
    endtask

    task automatic drain();
        do
            @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || due_results.size() != 0);
    endtask

    always @(posedge aclk) begin : drive_input
        element_t sent_item;
        element_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                sent_item.value = s_value;
                sent_item.last = s_last;
                due_results.push_back(predict_dedup(sent_item));
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_item = pending_items.pop_front();
                    s_value <= next_item.value;
                    s_last <= next_item.last;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : watch_output
        verdict_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("transfer with no result due", 32'h0, m_item_value);
                end else begin
                    want = due_results.pop_front();
                    if (m_item_value !== want.item_value)
                        report_mismatch("item_value", want.item_value, m_item_value);
                    if (m_kept !== want.kept)
                        report_mismatch("kept", 32'(want.kept), 32'(m_kept));
                    if (m_distinct_count !== want.distinct_count)
                        report_mismatch("distinct_count", 32'(want.distinct_count),
                                        32'(m_distinct_count));
                    if (m_overflow !== want.overflow)
                        report_mismatch("overflow", 32'(want.overflow), 32'(m_overflow));
                    if (m_set_end !== want.set_end)
                        report_mismatch("set_end", 32'(want.set_end), 32'(m_set_end));
                    results_checked++;
                    if (want.overflow)
                        overflow_seen++;
                    if (want.set_end)
                        sets_closed++;
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // extremes, repeats, single-element sets
        push_element(32'sh8000_0000, 1'b1);
        push_element(32'sh7fff_ffff, 1'b0);
        push_element(32'sh8000_0000, 1'b0);
        push_element(32'sh0000_0000, 1'b0);
        push_element(32'shffff_ffff, 1'b0);
        push_element(32'sh7fff_ffff, 1'b0);
        push_element(32'sh0000_0000, 1'b0);
        push_element(32'sh0000_0001, 1'b0);
        push_element(32'shffff_ffff, 1'b1);
        push_element(32'sh0000_0000, 1'b1);
        push_element(32'sh0000_0005, 1'b0);
        push_element(32'sh0000_0005, 1'b0);
        push_element(32'sh0000_0005, 1'b0);
        push_element(32'sh0000_0005, 1'b1);
        push_element(32'sh5555_5555, 1'b0);
        push_element(32'shaaaa_aaaa, 1'b0);
        push_element(32'sh5555_5554, 1'b1);

        build_phase(120, 1'b1);
        drain();

        sender_idle_pct <= 70;
        receiver_stall_pct <= 19;
        build_phase(120, 1'b1);
        drain();

        sender_idle_pct <= 0;
        receiver_stall_pct <= 0;
        build_phase(120, 1'b0);
        drain();

        repeat (20) @(posedge aclk);
        if (due_results.size() != 0)
            report_mismatch("results never delivered", due_results.size(), 32'h0);

        $display("Sent %0d elements in %0d sets; %0d results checked, %0d with overflow.",
                 items_sent, sets_closed, results_checked, overflow_seen);
        $display("Flow control: sender gaps and receiver stalls swapped, then none.");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout: %0d elements sent, %0d results checked", items_sent,
                 results_checked);
        $display("Mismatches found");
        $finish;
    end

endmodule
